FILE: sv/qslerp_pkg.sv
// Shared types, constants and helpers for the quaternion slerp pipeline.
// No dependencies.
package qslerp_pkg;

  localparam int FRAC_BITS           = 14;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANG_W               = 34;
  localparam logic [30:0] SIN_MIN    = 31'd1073742;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] first_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic signed [15:0] second_w;
    logic        [16:0] blend;
  } slerp_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
  } slerp_out_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] r;
    r = '0;
    unique case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      default: begin
        if (i <= 30) r = ANG_W'((64'sd1 <<< (30 - i)) - 64'sd1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    logic signed [15:0] r;
    if (v > 52'sd32767) r = 16'sh7fff;
    else if (v < -52'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

FILE: sv/quaternion_slerp_top.sv
// Quaternion slerp top level: dot, square root, CORDIC, divide, blend.
// Depends on qslerp_pkg, qslerp_sqrt, qslerp_cordic, qslerp_div.
//
//   channel | signals                    | role
//   req     | req_valid, req_stall, req  | quaternion pair and blend in
//   rsp     | rsp_valid, rsp_stall, rsp  | interpolated quaternion out
//
// One transfer per cycle in each direction while rsp is not stalled. The pipeline has
// 32 root stages, two CORDIC runs, 33 divider stages and 7 arithmetic stages.
// Reset clears only the stage valid bits.
// A stalled rsp freezes the whole pipeline and raises req_stall in the same cycle.
module quaternion_slerp_top #(
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  qslerp_pkg::slerp_in_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output qslerp_pkg::slerp_out_t rsp
);
  import qslerp_pkg::*;

  localparam int CSH = 30 - 2 * FRAC_BITS;

  typedef logic [3:0][15:0] quad_t;

  typedef struct packed {
    quad_t       a;
    quad_t       b;
    quad_t       lin;
    logic [16:0] t;
    logic        neg;
    logic        big;
    logic [29:0] c30;
  } sq_side_t;

  typedef struct packed {
    quad_t       a;
    quad_t       b;
    quad_t       lin;
    logic [16:0] t;
    logic        neg;
    logic        big;
    logic        low_sin;
    logic [30:0] s30;
  } vec_side_t;

  typedef struct packed {
    quad_t       a;
    quad_t       b;
    quad_t       lin;
    logic        neg;
    logic        big;
    logic        low_sin;
    logic [30:0] den;
  } rot_side_t;

  typedef struct packed {
    quad_t a;
    quad_t b;
    quad_t lin;
    logic  neg;
    logic  big;
    logic  low_sin;
  } div_side_t;

  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // stage 1: products
  logic v1;
  quad_t a1, b1;
  logic [16:0] t1;
  logic signed [31:0] p1 [0:3];
  // stage 2: dot
  logic v2, big2, neg2;
  quad_t a2, b2;
  logic [16:0] t2, ta2;
  logic [29:0] c30_2;
  logic [59:0] csq;
  logic signed [33:0] dot;
  logic signed [33:0] cmag;
  // stage 3: square and linear products
  logic v3, big3, neg3;
  quad_t a3, b3;
  logic [16:0] t3;
  logic [29:0] c30_3;
  logic [60:0] rad3;
  logic signed [33:0] la3 [0:3];
  logic signed [33:0] lb3 [0:3];
  // stage 4: linear blend
  logic v4;
  logic [60:0] rad4;
  sq_side_t s4;
  quad_t lin_c;

  quad_t ain, bin;
  assign ain = {req.first_w, req.first_z, req.first_y, req.first_x};
  assign bin = {req.second_w, req.second_z, req.second_y, req.second_x};

  assign csq = c30_2 * c30_2;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) dot = dot + 34'(p1[i]);
    cmag = dot[33] ? -dot : dot;
  end

  always_comb begin
    logic signed [35:0] acc;
    for (int i = 0; i < 4; i++) begin
      acc = neg3 ? (36'(la3[i]) - 36'(lb3[i])) : (36'(la3[i]) + 36'(lb3[i]));
      acc = (acc + 36'sd32768) >>> 16;
      lin_c[i] = sat16(52'(acc));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      a1 <= ain;
      b1 <= bin;
      t1 <= (req.blend > 17'd65536) ? 17'd65536 : req.blend;
      for (int i = 0; i < 4; i++) p1[i] <= $signed(ain[i]) * $signed(bin[i]);

      a2 <= a1;
      b2 <= b1;
      t2 <= t1;
      ta2 <= 17'(18'd65536 - {1'b0, t1});
      big2 <= (dot >= 34'sd268435456) || (dot <= -34'sd268435456);
      neg2 <= dot[33];
      c30_2 <= 30'(cmag << CSH);

      a3 <= a2;
      b3 <= b2;
      t3 <= t2;
      big3 <= big2;
      neg3 <= neg2;
      c30_3 <= c30_2;
      rad3 <= (61'd1 << 60) - {1'b0, csq};
      for (int i = 0; i < 4; i++) begin
        la3[i] <= $signed({1'b0, ta2}) * $signed(a2[i]);
        lb3[i] <= $signed({1'b0, t2}) * $signed(b2[i]);
      end

      rad4 <= rad3;
      s4 <= '{a: a3, b: b3, lin: lin_c, t: t3, neg: neg3, big: big3, c30: c30_3};
    end
  end

  // square root
  logic v5;
  logic [30:0] s30_5;
  sq_side_t s5;

  qslerp_sqrt #(.SIDE_W($bits(sq_side_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(v4), .rad(rad4), .side_i(s4),
    .valid_o(v5), .root(s30_5), .side_o(s5)
  );

  // half angle
  vec_side_t vs_in, vs_out;
  logic vv;
  logic signed [ANG_W-1:0] vx, vz;

  assign vs_in = '{a: s5.a, b: s5.b, lin: s5.lin, t: s5.t, neg: s5.neg, big: s5.big,
                   low_sin: (s30_5 < SIN_MIN), s30: s30_5};

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b1),
                  .SIDE_W($bits(vec_side_t))) u_vec (
    .clk(clk), .rst(rst), .en(en), .valid_i(v5),
    .x_i(ANG_W'({1'b0, s5.c30})), .y_i(ANG_W'({1'b0, s30_5})), .z_i('0),
    .side_i(vs_in), .valid_o(vv), .x_o(vx), .y_o(), .z_o(vz), .side_o(vs_out)
  );

  // stage 6: scaled angle and divisor
  logic v6;
  logic [30:0] th6, tth6;
  logic signed [63:0] dr6;
  vec_side_t vs6;
  logic [30:0] thc;
  logic [47:0] tprod;

  assign thc   = vz[ANG_W-1] ? 31'd0 : vz[30:0];
  assign tprod = thc * vs_out.t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vv;
    end
    if (en) begin
      th6  <= thc;
      tth6 <= tprod[46:16];
      dr6  <= $signed(vx[31:0]) * $signed({1'b0, vs_out.s30});
      vs6  <= vs_out;
    end
  end

  logic signed [63:0] dsh;
  logic [30:0] den6;
  rot_side_t rs_in, rs_out;
  logic vr;
  logic signed [ANG_W-1:0] sa, sb;

  assign dsh  = dr6 >>> 30;
  assign den6 = (dsh <= 64'sd0) ? 31'd1 : dsh[30:0];
  assign rs_in = '{a: vs6.a, b: vs6.b, lin: vs6.lin, neg: vs6.neg, big: vs6.big,
                   low_sin: vs6.low_sin, den: den6};

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0),
                  .SIDE_W($bits(rot_side_t))) u_rot_a (
    .clk(clk), .rst(rst), .en(en), .valid_i(v6),
    .x_i(ANG_W'(64'sd1 <<< 30)), .y_i('0),
    .z_i($signed({3'b0, th6}) - $signed({3'b0, tth6})),
    .side_i(rs_in), .valid_o(vr), .x_o(), .y_o(sa), .z_o(), .side_o(rs_out)
  );

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0), .SIDE_W(1)) u_rot_b (
    .clk(clk), .rst(rst), .en(en), .valid_i(v6),
    .x_i(ANG_W'(64'sd1 <<< 30)), .y_i('0), .z_i($signed({3'b0, tth6})),
    .side_i(1'b0), .valid_o(), .x_o(), .y_o(sb), .z_o(), .side_o()
  );

  // weights
  div_side_t ds_in, ds_out;
  logic vd;
  logic signed [ANG_W-1:0] wa, wb;

  assign ds_in = '{a: rs_out.a, b: rs_out.b, lin: rs_out.lin, neg: rs_out.neg,
                   big: rs_out.big, low_sin: rs_out.low_sin};

  qslerp_div #(.SIDE_W($bits(div_side_t))) u_div_a (
    .clk(clk), .rst(rst), .en(en), .valid_i(vr), .num(sa), .den(rs_out.den),
    .side_i(ds_in), .valid_o(vd), .quo(wa), .side_o(ds_out)
  );

  qslerp_div #(.SIDE_W(1)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .valid_i(vr), .num(sb), .den(rs_out.den),
    .side_i(1'b0), .valid_o(), .quo(wb), .side_o()
  );

  // stage 8: weighted products, stage 9: output
  logic v8;
  div_side_t ds8;
  logic signed [49:0] pa8 [0:3];
  logic signed [49:0] pb8 [0:3];
  quad_t res;

  always_comb begin
    logic signed [51:0] acc;
    for (int i = 0; i < 4; i++) begin
      acc = ds8.neg ? (52'(pa8[i]) - 52'(pb8[i])) : (52'(pa8[i]) + 52'(pb8[i]));
      acc = (acc + (52'sd1 <<< 29)) >>> 30;
      if (ds8.big) res[i] = ds8.a[i];
      else if (ds8.low_sin) res[i] = ds8.lin[i];
      else res[i] = sat16(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v8 <= vd;
      rsp_valid <= v8;
    end
    if (en) begin
      ds8 <= ds_out;
      for (int i = 0; i < 4; i++) begin
        pa8[i] <= wa * $signed(ds_out.a[i]);
        pb8[i] <= wb * $signed(ds_out.b[i]);
      end
      rsp.out_x <= res[0];
      rsp.out_y <= res[1];
      rsp.out_z <= res[2];
      rsp.out_w <= res[3];
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("result dropped while stalled");
  a_angle: assert property (@(posedge clk) disable iff (rst)
    (vv && !vs_out.big && !vs_out.low_sin) |-> !vz[ANG_W-1])
    else $error("negative half angle outside linear case");
  a_den: assert property (@(posedge clk) disable iff (rst)
    (v6 && !vs6.big && !vs6.low_sin) |-> (dsh > 64'sd0))
    else $error("nonpositive divisor outside linear case");

endmodule

FILE: sv/qslerp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qslerp_pkg (import only for house style).
module qslerp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  logic [60:0]       rad,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [30:0]       root,
  output logic [SIDE_W-1:0] side_o
);
  import qslerp_pkg::*;

  localparam int N = 32;

  logic [N-1:0]      vld;
  logic [63:0]       vr   [0:N-1];
  logic [63:0]       rr   [0:N-1];
  logic [SIDE_W-1:0] sd   [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [63:0]       v_in, r_in, sum, bitv;
    logic [SIDE_W-1:0] s_in;
    logic              vi;
    if (k == 0) begin : g_first
      assign v_in = {3'b0, rad};
      assign r_in = '0;
      assign s_in = side_i;
      assign vi   = valid_i;
    end else begin : g_rest
      assign v_in = vr[k-1];
      assign r_in = rr[k-1];
      assign s_in = sd[k-1];
      assign vi   = vld[k-1];
    end
    assign bitv = 64'd1 << (62 - 2 * k);
    assign sum  = r_in + bitv;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vi;
      end
      if (en) begin
        sd[k] <= s_in;
        if (v_in >= sum) begin
          vr[k] <= v_in - sum;
          rr[k] <= (r_in >> 1) + bitv;
        end else begin
          vr[k] <= v_in;
          rr[k] <= r_in >> 1;
        end
      end
    end
  end

  assign valid_o = vld[N-1];
  assign root    = rr[N-1][30:0];
  assign side_o  = sd[N-1];

endmodule

FILE: sv/qslerp_cordic.sv
// Pipelined CORDIC, vectoring or rotation mode, one iteration per stage.
// Depends on qslerp_pkg for the arctangent table and angle width.
module qslerp_cordic #(
  parameter int STEPS     = 16,
  parameter bit VECTORING = 1'b1,
  parameter int SIDE_W    = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [qslerp_pkg::ANG_W-1:0] x_i,
  input  logic signed [qslerp_pkg::ANG_W-1:0] y_i,
  input  logic signed [qslerp_pkg::ANG_W-1:0] z_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [qslerp_pkg::ANG_W-1:0] x_o,
  output logic signed [qslerp_pkg::ANG_W-1:0] y_o,
  output logic signed [qslerp_pkg::ANG_W-1:0] z_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import qslerp_pkg::*;

  logic [STEPS-1:0]        vld;
  logic signed [ANG_W-1:0] xr [0:STEPS-1];
  logic signed [ANG_W-1:0] yr [0:STEPS-1];
  logic signed [ANG_W-1:0] zr [0:STEPS-1];
  logic [SIDE_W-1:0]       sd [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    logic signed [ANG_W-1:0] xa, ya, za, dx, dy;
    logic [SIDE_W-1:0]       s_in;
    logic                    vi, up;
    if (i == 0) begin : g_first
      assign xa = x_i;
      assign ya = y_i;
      assign za = z_i;
      assign s_in = side_i;
      assign vi = valid_i;
    end else begin : g_rest
      assign xa = xr[i-1];
      assign ya = yr[i-1];
      assign za = zr[i-1];
      assign s_in = sd[i-1];
      assign vi = vld[i-1];
    end
    assign dx = ya >>> i;
    assign dy = xa >>> i;
    assign up = VECTORING ? (ya >= 0) : (za >= 0);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vi;
      end
      if (en) begin
        sd[i] <= s_in;
        if (VECTORING) begin
          if (up) begin
            xr[i] <= xa + dx;
            yr[i] <= ya - dy;
            zr[i] <= za + atan_entry(i);
          end else begin
            xr[i] <= xa - dx;
            yr[i] <= ya + dy;
            zr[i] <= za - atan_entry(i);
          end
        end else begin
          if (up) begin
            xr[i] <= xa - dx;
            yr[i] <= ya + dy;
            zr[i] <= za - atan_entry(i);
          end else begin
            xr[i] <= xa + dx;
            yr[i] <= ya - dy;
            zr[i] <= za + atan_entry(i);
          end
        end
      end
    end
  end

  assign valid_o = vld[STEPS-1];
  assign x_o     = xr[STEPS-1];
  assign y_o     = yr[STEPS-1];
  assign z_o     = zr[STEPS-1];
  assign side_o  = sd[STEPS-1];

endmodule

FILE: sv/qslerp_div.sv
// Pipelined restoring divider: q = trunc(num * 2^30 / den), one bit per stage.
// Depends on qslerp_pkg for the angle width.
module qslerp_div #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [qslerp_pkg::ANG_W-1:0] num,
  input  logic [30:0]                       den,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [qslerp_pkg::ANG_W-1:0] quo,
  output logic [SIDE_W-1:0]                 side_o
);
  import qslerp_pkg::*;

  localparam int N = 33;

  logic [ANG_W-1:0]  mag;
  logic [63:0]       dividend;

  logic [N-1:0]      vld;
  logic [30:0]       rem [0:N-1];
  logic [N-1:0]      qr  [0:N-1];
  logic [N-1:0]      lo  [0:N-1];
  logic [30:0]       dv  [0:N-1];
  logic              sg  [0:N-1];
  logic [SIDE_W-1:0] sd  [0:N-1];

  assign mag      = num[ANG_W-1] ? ANG_W'(-num) : ANG_W'(num);
  assign dividend = {mag[33:0], 30'b0};

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [30:0]       r_in, d_in;
    logic [N-1:0]      q_in, l_in;
    logic              s_g, vi;
    logic [SIDE_W-1:0] s_in;
    logic [31:0]       r2;
    if (k == 0) begin : g_first
      assign r_in = dividend[63:33];
      assign q_in = '0;
      assign l_in = dividend[32:0];
      assign d_in = den;
      assign s_g  = num[ANG_W-1];
      assign s_in = side_i;
      assign vi   = valid_i;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign q_in = qr[k-1];
      assign l_in = lo[k-1];
      assign d_in = dv[k-1];
      assign s_g  = sg[k-1];
      assign s_in = sd[k-1];
      assign vi   = vld[k-1];
    end
    assign r2 = {r_in, l_in[N-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vi;
      end
      if (en) begin
        lo[k] <= l_in << 1;
        dv[k] <= d_in;
        sg[k] <= s_g;
        sd[k] <= s_in;
        if (r2 >= {1'b0, d_in}) begin
          rem[k] <= 31'(r2 - {1'b0, d_in});
          qr[k]  <= {q_in[N-2:0], 1'b1};
        end else begin
          rem[k] <= r2[30:0];
          qr[k]  <= {q_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld[N-1];
  assign quo     = sg[N-1] ? -$signed({1'b0, qr[N-1]}) : $signed({1'b0, qr[N-1]});
  assign side_o  = sd[N-1];

endmodule
